// ===== rtl/rlsf_pkg.sv =====
// Package with shared types, constants and codes of the RPM lag and slew filter.
package rlsf_pkg;

  localparam int unsigned NumFans  = 8;
  localparam int unsigned FanBits  = 3;
  localparam int unsigned RpmBits  = 16;
  localparam int unsigned TimeBits = 32;

  localparam int unsigned CfgBits    = 16;
  localparam int unsigned CfgIdxBits = 3;
  localparam int unsigned AlphaShift = 12;
  localparam int unsigned MsPerS     = 1000;
  localparam int unsigned MinFloor   = 10;

  typedef enum logic [CfgIdxBits-1:0] {
    REG_MAX_RPM  = 3'd0,
    REG_STOP_RPM = 3'd1,
    REG_TAU_MS   = 3'd2,
    REG_SLEW     = 3'd3,
    REG_MIN_DT   = 3'd4,
    REG_MAX_DT   = 3'd5
  } reg_idx_e;

  typedef enum logic [1:0] {
    KIND_STOPPED   = 2'd0,
    KIND_SNAPPED   = 2'd1,
    KIND_UNCHANGED = 2'd2,
    KIND_STEP      = 2'd3
  } kind_e;

  typedef struct packed {
    logic [FanBits-1:0]  fan_index;
    logic [RpmBits-1:0]  raw_rpm;
    logic [TimeBits-1:0] now_ms;
  } in_item_t;

  typedef struct packed {
    logic [RpmBits-1:0] filtered_rpm;
    logic [1:0]         update_kind;
  } out_item_t;

  typedef struct packed {
    logic [CfgBits-1:0] max_rpm;
    logic [CfgBits-1:0] stop_rpm;
    logic [CfgBits-1:0] tau_ms;
    logic [CfgBits-1:0] slew;
    logic [CfgBits-1:0] min_dt;
    logic [CfgBits-1:0] max_dt;
  } cfg_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic decide;
    logic div_start;
    logic div_step;
    logic mul_step;
    logic finish;
    logic commit;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic need_filter;
  } dp_sts_t;

endpackage

// ===== rtl/rlsf_ctrl.sv =====
// Controller state machine sequencing the serial divide and multiply steps.
module rlsf_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output rlsf_pkg::dp_cmd_t cmd_o,
  input  rlsf_pkg::dp_sts_t sts_i
);
  import rlsf_pkg::*;

  localparam int unsigned DivSteps = 29;
  localparam int unsigned MulSteps = 13;

  typedef enum logic [2:0] {
    ST_IDLE, ST_DECIDE, ST_DIV, ST_MUL, ST_FINISH, ST_OUT
  } state_e;

  state_e     state_q, state_d;
  logic [4:0] cnt_q, cnt_d;
  logic       out_valid_q, out_valid_d;
  logic       in_fire;

  // The output register frees once its beat is taken, so a new item may enter.
  assign in_stall_o = (state_q != ST_IDLE) || (out_valid_q && out_stall_i);
  assign in_fire    = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q && out_stall_i;
    cmd_o       = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          cmd_o.load = 1'b1;
          state_d    = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        cmd_o.decide = 1'b1;
        if (sts_i.need_filter) begin
          cmd_o.div_start = 1'b1;
          cnt_d   = '0;
          state_d = ST_DIV;
        end else begin
          state_d = ST_OUT;
        end
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == 5'(DivSteps - 1)) begin
          cnt_d   = '0;
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd_o.mul_step = 1'b1;
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == 5'(MulSteps - 1)) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        cmd_o.finish = 1'b1;
        state_d = ST_OUT;
      end
      ST_OUT: begin
        if (!(out_valid_q && out_stall_i)) begin
          cmd_o.commit = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ===== rtl/rlsf_dp.sv =====
// Datapath: channel stores, decision logic, serial divider and serial multiplier.
module rlsf_dp (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  rlsf_pkg::cfg_t      cfg_i,
  input  rlsf_pkg::in_item_t  in_data_i,
  input  rlsf_pkg::dp_cmd_t   cmd_i,
  output rlsf_pkg::dp_sts_t   sts_o,
  output rlsf_pkg::out_item_t out_data_o
);
  import rlsf_pkg::*;

  localparam int unsigned ChBits = FanBits;
  localparam int unsigned DtBits = 16;
  localparam int unsigned QuoBits = DtBits + AlphaShift + 1;
  localparam int unsigned DenBits = DtBits + 1;
  localparam int unsigned ProdBits = RpmBits + AlphaShift + 1;
  localparam int unsigned LimBits = 32;
  localparam int unsigned SlewBits = 2 * CfgBits;
  localparam int unsigned LimDiv = MsPerS / 8;
  localparam int unsigned RecipShift = 36;
  localparam int unsigned RecipBits = 30;
  localparam int unsigned LimProdBits = SlewBits - 3 + RecipBits;
  localparam logic [RecipBits-1:0] LimRecip =
    RecipBits'(((64'd1 << RecipShift) + 64'(LimDiv) - 64'd1) / 64'(LimDiv));

  logic [RpmBits-1:0]  filt_q [NumFans];
  logic [TimeBits-1:0] time_q [NumFans];
  logic [NumFans-1:0]  seen_q;

  logic [ChBits-1:0]    ch_q;
  logic [RpmBits-1:0]   raw_q, old_q, res_q;
  logic [TimeBits-1:0]  now_q, dt_q;
  logic                 seen_now_q;
  logic [1:0]           kind_q;
  logic                 neg_q;
  logic [RpmBits-1:0]   mag_q;
  logic [QuoBits-1:0]   quo_q;
  logic [DenBits:0]     rem_q;
  logic [DenBits-1:0]   den_q;
  logic [ProdBits-1:0]  prod_q;
  logic [AlphaShift:0]  alpha_q;
  logic [LimBits-1:0]   lim_q;
  logic [SlewBits-1:0]  slew_dt_q;
  logic [4:0]           mcnt_q;

  logic [ChBits-1:0]    ch_in;
  logic [RpmBits-1:0]   raw_in;
  logic [TimeBits-1:0]  now_in;
  logic [CfgBits-1:0]   floor_rpm;
  logic                 stop_c, snap_c;

  assign ch_in  = in_data_i.fan_index;
  assign raw_in = in_data_i.raw_rpm;
  assign now_in = in_data_i.now_ms;

  assign floor_rpm = (cfg_i.stop_rpm > CfgBits'(MinFloor)) ? cfg_i.stop_rpm
                                                           : CfgBits'(MinFloor);
  assign stop_c = ({8'd0, raw_q} < {8'd0, floor_rpm});
  assign snap_c = !seen_now_q || (dt_q < TimeBits'(cfg_i.min_dt)) ||
                  (dt_q > TimeBits'(cfg_i.max_dt));
  assign sts_o.need_filter = !stop_c && !snap_c && (raw_q != old_q);

  // Restoring divider state for one bit of alpha.
  logic [DenBits:0] rem_sh;
  assign rem_sh = {rem_q[DenBits-1:0], quo_q[QuoBits-1]};

  // Dividing by 1000 is a shift by three and a reciprocal multiply for 125.
  logic [LimProdBits-1:0] lim_prod;
  assign lim_prod = LimProdBits'(slew_dt_q[SlewBits-1:3]) * LimProdBits'(LimRecip);

  // Final step: nudge, slew clamp, floor at zero.
  logic [RpmBits:0]   step_mag;
  logic [RpmBits+1:0] nxt;
  logic [LimBits-1:0] lim_eff;
  always_comb begin
    // Floor shift of a negative product rounds its magnitude up.
    if (neg_q) step_mag = (RpmBits+1)'((prod_q + ProdBits'((1 << AlphaShift) - 1))
                                       >> AlphaShift);
    else step_mag = (RpmBits+1)'(prod_q >> AlphaShift);
    if (step_mag == '0) step_mag = (RpmBits+1)'(1);
    lim_eff = (lim_q == '0) ? LimBits'(1) : lim_q;
    if (LimBits'(step_mag) > lim_eff) step_mag = (RpmBits+1)'(lim_eff);
    if (neg_q) begin
      if ({1'b0, step_mag} > {2'b0, old_q}) nxt = '0;
      else nxt = {2'b0, old_q} - {1'b0, step_mag};
    end else begin
      nxt = {2'b0, old_q} + {1'b0, step_mag};
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      ch_q       <= ch_in;
      raw_q      <= (raw_in > RpmBits'(cfg_i.max_rpm)) ? RpmBits'(cfg_i.max_rpm) : raw_in;
      now_q      <= now_in;
      old_q      <= seen_q[ch_in] ? filt_q[ch_in] : '0;
      seen_now_q <= seen_q[ch_in];
      dt_q       <= now_in - (seen_q[ch_in] ? time_q[ch_in] : '0);
    end
    if (cmd_i.decide) begin
      if (stop_c) begin
        kind_q <= KIND_STOPPED;
        res_q  <= '0;
      end else if (snap_c) begin
        kind_q <= KIND_SNAPPED;
        res_q  <= raw_q;
      end else begin
        kind_q <= (raw_q == old_q) ? KIND_UNCHANGED : KIND_STEP;
        res_q  <= old_q;
      end
      neg_q <= raw_q < old_q;
      mag_q <= (raw_q < old_q) ? old_q - raw_q : raw_q - old_q;
    end
    if (cmd_i.div_start) begin
      quo_q     <= QuoBits'({dt_q[DtBits-1:0], AlphaShift'(0)});
      rem_q     <= '0;
      den_q     <= DenBits'(cfg_i.tau_ms) + DenBits'(dt_q[DtBits-1:0]);
      // The slew budget product is registered; its scaling runs during the divide.
      slew_dt_q <= SlewBits'(cfg_i.slew) * SlewBits'(dt_q[DtBits-1:0]);
      mcnt_q    <= '0;
    end
    if (cmd_i.div_step) begin
      if (den_q != '0 && rem_sh >= {1'b0, den_q}) begin
        rem_q <= rem_sh - {1'b0, den_q};
        quo_q <= {quo_q[QuoBits-2:0], 1'b1};
      end else begin
        rem_q <= rem_sh;
        quo_q <= {quo_q[QuoBits-2:0], 1'b0};
      end
      prod_q <= '0;
      lim_q  <= LimBits'(lim_prod >> RecipShift);
    end
    if (cmd_i.mul_step) begin
      if (mcnt_q == '0) begin
        alpha_q <= quo_q[AlphaShift:0] >> 1;
        prod_q  <= (quo_q[0]) ? ProdBits'(mag_q) : '0;
      end else begin
        prod_q  <= alpha_q[0] ? prod_q + (ProdBits'(mag_q) << mcnt_q) : prod_q;
        alpha_q <= alpha_q >> 1;
      end
      mcnt_q <= mcnt_q + 5'd1;
    end
    if (cmd_i.finish) begin
      res_q <= nxt[RpmBits-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q <= '0;
    end else if (cmd_i.commit) begin
      seen_q[ch_q] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      filt_q[ch_q] <= res_q;
      time_q[ch_q] <= now_q;
      out_data_o.filtered_rpm <= res_q;
      out_data_o.update_kind  <= kind_q;
    end
  end

endmodule

// ===== rtl/rpm_lag_slew_filter.sv =====
// Top level of the per-channel RPM lag filter with slew limit.
//
//  Channel  Handshake           Beat
//  in       in_valid/in_stall   fan_index, raw_rpm, now_ms
//  out      out_valid/out_stall filtered_rpm, update_kind
//  cfg      cfg_valid/cfg_ready register index, 16-bit data
//
// A stop, snap or unchanged sample goes through the load, decide and output states.
// A filtered step also runs the bit-serial alpha divider, then the shift-add
// multiplier and a finish state before the output state.
// Reset clears the seen flags; the stores need no clearing pass.
// A stalled result holds the output register; the next item waits for it.
module rpm_lag_slew_filter (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  rlsf_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output rlsf_pkg::out_item_t out_data_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [2:0]          cfg_index_i,
  input  logic [15:0]         cfg_data_i
);
  import rlsf_pkg::*;

  cfg_t    cfg_q;
  dp_cmd_t cmd;
  dp_sts_t sts;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.max_rpm  <= 16'd5000;
      cfg_q.stop_rpm <= 16'd50;
      cfg_q.tau_ms   <= 16'd1000;
      cfg_q.slew     <= 16'd1500;
      cfg_q.min_dt   <= 16'd100;
      cfg_q.max_dt   <= 16'd5000;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_MAX_RPM:  cfg_q.max_rpm  <= cfg_data_i;
        REG_STOP_RPM: cfg_q.stop_rpm <= cfg_data_i;
        REG_TAU_MS:   cfg_q.tau_ms   <= cfg_data_i;
        REG_SLEW:     cfg_q.slew     <= cfg_data_i;
        REG_MIN_DT:   cfg_q.min_dt   <= cfg_data_i;
        REG_MAX_DT:   cfg_q.max_dt   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  rlsf_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .out_valid_o, .out_stall_i,
    .cmd_o(cmd), .sts_i(sts)
  );

  rlsf_dp u_dp (
    .clk_i, .rst_ni, .cfg_i(cfg_q), .in_data_i, .cmd_i(cmd), .sts_o(sts),
    .out_data_o
  );

  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o) else $error("accept while busy");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> $stable(out_data_o)) else $error("result moved");
  a_one_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.load, cmd.div_step, cmd.mul_step, cmd.finish, cmd.commit}))
    else $error("overlapping commands");

endmodule

// ===== tb/sv/rpm_lag_slew_filter_checker.sv =====
// Checker that predicts and compares the filtered RPM results of the block.
`timescale 1ns / 100ps
module rpm_lag_slew_filter_checker (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_stall_i,
  input  rlsf_pkg::in_item_t  in_data_i,
  input  logic                out_valid_i,
  input  logic                out_stall_i,
  input  rlsf_pkg::out_item_t out_data_i,
  input  logic                cfg_valid_i,
  input  logic                cfg_ready_i,
  input  logic [2:0]          cfg_index_i,
  input  logic [15:0]         cfg_data_i,
  output int                  errors_o,
  output int                  pending_o,
  output int                  results_o,
  output int                  steps_o
);
  import rlsf_pkg::*;

  logic [15:0] max_rpm, stop_rpm, tau_ms, slew, min_dt, max_dt;
  logic [15:0] fan_rpm [8];
  logic [31:0] fan_time [8];
  logic        fan_seen [8];
  out_item_t   expected_q [$];

  function automatic out_item_t filter_sample(in_item_t s);
    int unsigned ch;
    logic [15:0] raw, flr, old;
    logic [31:0] dt;
    longint delta, alpha, prod, step, lim, val;
    out_item_t r;
    ch = s.fan_index;
    raw = s.raw_rpm;
    if (raw > max_rpm) raw = max_rpm;
    flr = (stop_rpm > 16'd10) ? stop_rpm : 16'd10;
    old = fan_rpm[ch];
    dt = s.now_ms - fan_time[ch];
    if (raw < flr) begin
      fan_rpm[ch] = '0;
      r.update_kind = KIND_STOPPED;
    end else if (!fan_seen[ch] || dt < min_dt || dt > max_dt) begin
      fan_rpm[ch] = raw;
      r.update_kind = KIND_SNAPPED;
    end else if (raw == old) begin
      r.update_kind = KIND_UNCHANGED;
    end else begin
      delta = longint'(raw) - longint'(old);
      alpha = (tau_ms + dt == 0) ? 0 : (longint'(dt) << 12) / (longint'(tau_ms) + dt);
      prod = delta * alpha;
      // Arithmetic shift gives the floor for negative products.
      step = prod >>> 12;
      if (step == 0) step = (delta > 0) ? 1 : -1;
      lim = (longint'(slew) * dt) / 1000;
      if (lim < 1) lim = 1;
      if (step > lim) step = lim;
      else if (step < -lim) step = -lim;
      val = longint'(old) + step;
      if (val < 0) val = 0;
      fan_rpm[ch] = val[15:0];
      r.update_kind = KIND_STEP;
    end
    fan_time[ch] = s.now_ms;
    fan_seen[ch] = 1'b1;
    r.filtered_rpm = fan_rpm[ch];
    return r;
  endfunction

  assign pending_o = expected_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t e;
    if (!rst_ni) begin
      max_rpm <= 16'd5000; stop_rpm <= 16'd50; tau_ms <= 16'd1000;
      slew <= 16'd1500; min_dt <= 16'd100; max_dt <= 16'd5000;
      for (int i = 0; i < 8; i++) begin
        fan_rpm[i] = '0; fan_time[i] = '0; fan_seen[i] = 1'b0;
      end
      expected_q.delete();
      errors_o <= 0; results_o <= 0; steps_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          REG_MAX_RPM:  max_rpm <= cfg_data_i;
          REG_STOP_RPM: stop_rpm <= cfg_data_i;
          REG_TAU_MS:   tau_ms <= cfg_data_i;
          REG_SLEW:     slew <= cfg_data_i;
          REG_MIN_DT:   min_dt <= cfg_data_i;
          REG_MAX_DT:   max_dt <= cfg_data_i;
          default: ;
        endcase
      end
      if (out_valid_i && !out_stall_i) begin
        results_o <= results_o + 1;
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected beat rpm=%0d kind=%0d", $time,
                   out_data_i.filtered_rpm, out_data_i.update_kind);
          errors_o <= errors_o + 1;
        end else begin
          e = expected_q.pop_front();
          if (e.update_kind == KIND_STEP) steps_o <= steps_o + 1;
          if (e.filtered_rpm !== out_data_i.filtered_rpm) begin
            $display("%0t: filtered_rpm expected %0d actual %0d", $time,
                     e.filtered_rpm, out_data_i.filtered_rpm);
            errors_o <= errors_o + 1;
          end else if (e.update_kind !== out_data_i.update_kind) begin
            $display("%0t: update_kind expected %0d actual %0d", $time,
                     e.update_kind, out_data_i.update_kind);
            errors_o <= errors_o + 1;
          end
        end
      end
      if (in_valid_i && !in_stall_i) expected_q.push_back(filter_sample(in_data_i));
    end
  end
endmodule

// ===== tb/sv/rpm_lag_slew_filter_test.sv =====
// Top of the RPM lag filter testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps
module rpm_lag_slew_filter_test;
  import rlsf_pkg::*;

  logic clk, rst_n;
  logic in_valid, in_stall, out_valid, out_stall;
  logic cfg_valid, cfg_ready;
  logic [2:0] cfg_index;
  logic [15:0] cfg_data;
  in_item_t in_data;
  out_item_t out_data;
  int errors, pending, results, steps;
  int send_idle_pct, recv_idle_pct, hold_cycles;
  longint cycles;
  logic [31:0] fan_clock [8];

  rpm_lag_slew_filter dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall), .in_data_i(in_data),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .out_data_o(out_data),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data)
  );

  rpm_lag_slew_filter_checker checker_u (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_i(in_stall), .in_data_i(in_data),
    .out_valid_i(out_valid), .out_stall_i(out_stall), .out_data_i(out_data),
    .cfg_valid_i(cfg_valid), .cfg_ready_i(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .errors_o(errors), .pending_o(pending), .results_o(results), .steps_o(steps)
  );

  always begin
    clk = 1'b0; #4;
    clk = 1'b1; #4;
  end

  // Receiver stall: random per phase, or a long hold-off when requested.
  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 2000000) begin
      $display("rpm_lag_slew_filter_test: done, errors");
      $finish;
    end
  end

  // The block is always busy in the cycle after an accept, so the gap costs nothing.
  task automatic send_beat(logic [2:0] fan, logic [15:0] rpm, logic [31:0] now);
    while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    in_valid <= 1'b1;
    in_data <= '{fan_index: fan, raw_rpm: rpm, now_ms: now};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_e idx, logic [15:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain();
    while (pending != 0) @(posedge clk);
    // Idle margin before the next step of the test.
    repeat (60) @(posedge clk);
  endtask

  // Mostly well-spaced samples per fan, with some odd intervals and raw values.
  task automatic random_samples(int count);
    logic [2:0] fan;
    logic [15:0] rpm;
    int unsigned pick;
    for (int i = 0; i < count; i++) begin
      fan = 3'($urandom_range(7));
      pick = $urandom_range(99);
      if (pick < 70) fan_clock[fan] += $urandom_range(1200, 80);
      else if (pick < 85) fan_clock[fan] += $urandom_range(8000);
      else fan_clock[fan] = $urandom;
      pick = $urandom_range(99);
      if (pick < 75) rpm = 16'($urandom_range(5200, 0));
      else if (pick < 85) rpm = 16'($urandom_range(60));
      else rpm = 16'($urandom);
      send_beat(fan, rpm, fan_clock[fan]);
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0; in_data = '0; out_stall = 1'b0;
    cfg_valid = 1'b0; cfg_index = REG_MAX_RPM; cfg_data = '0;
    cycles = 0; hold_cycles = 0; send_idle_pct = 0; recv_idle_pct = 0;
    for (int i = 0; i < 8; i++) fan_clock[i] = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: first samples, stop floor, clamp, unchanged, steps, wrap, extremes.
    send_beat(3'd0, 16'd3000, 32'd0);
    send_beat(3'd0, 16'd3000, 32'd500);
    send_beat(3'd0, 16'd4000, 32'd1000);
    send_beat(3'd0, 16'd100, 32'd2000);
    send_beat(3'd0, 16'd100, 32'd2100);
    send_beat(3'd0, 16'd9, 32'd2200);
    send_beat(3'd1, 16'hFFFF, 32'hFFFF_FF00);
    send_beat(3'd1, 16'd1000, 32'd200);
    send_beat(3'd1, 16'd1001, 32'd300);
    send_beat(3'd1, 16'd1000, 32'd400);
    send_beat(3'd2, 16'd2000, 32'd10);
    send_beat(3'd2, 16'd2000, 32'd50);
    send_beat(3'd2, 16'd2000, 32'd9000);
    send_beat(3'd7, 16'd49, 32'hFFFF_FFFF);
    send_beat(3'd7, 16'd50, 32'd99);
    drain();
    write_reg(REG_TAU_MS, 16'd0);
    write_reg(REG_MIN_DT, 16'd0);
    write_reg(REG_SLEW, 16'd0);
    write_reg(REG_MAX_RPM, 16'd0);
    send_beat(3'd3, 16'd500, 32'd0);
    drain();
    write_reg(REG_MAX_RPM, 16'hFFFF);
    write_reg(REG_STOP_RPM, 16'd0);
    write_reg(REG_MAX_DT, 16'hFFFF);
    write_reg(reg_idx_e'(3'd6), 16'd1234);
    send_beat(3'd3, 16'd500, 32'd1000);
    send_beat(3'd3, 16'd10, 32'd1000);
    send_beat(3'd3, 16'hFFFF, 32'd1000);
    send_beat(3'd3, 16'd20, 32'd66535);
    drain();
    write_reg(REG_TAU_MS, 16'hFFFF);
    write_reg(REG_SLEW, 16'hFFFF);
    write_reg(REG_STOP_RPM, 16'hFFFF);
    send_beat(3'd4, 16'hFFFF, 32'd5);
    send_beat(3'd4, 16'd0, 32'd1000);
    drain();

    // Random phases over several register settings.
    for (int ph = 0; ph < 8; ph++) begin
      write_reg(REG_MAX_RPM, (ph == 2) ? 16'hFFFF : 16'($urandom_range(6000, 1)));
      write_reg(REG_STOP_RPM, (ph == 3) ? 16'd0 : 16'($urandom_range(200)));
      write_reg(REG_TAU_MS, (ph == 4) ? 16'd1 : 16'($urandom_range(3000, 1)));
      write_reg(REG_SLEW, (ph == 5) ? 16'hFFFF : 16'($urandom_range(5000)));
      write_reg(REG_MIN_DT, (ph == 6) ? 16'd0 : 16'($urandom_range(150)));
      write_reg(REG_MAX_DT, (ph == 7) ? 16'hFFFF : 16'($urandom_range(6000, 1000)));
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
        1: begin send_idle_pct = 52; recv_idle_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_idle_pct = 52; end
        default: begin send_idle_pct = 6; recv_idle_pct = 6; end
      endcase
      if (ph == 1) hold_cycles = 400;
      random_samples(90);
      if (ph == 5) begin
        // Sender waits for every expected result before going on.
        while (pending != 0) @(posedge clk);
        random_samples(10);
      end
      drain();
    end

    $display("Covered %0d results, %0d filtered steps, over eight register settings.",
             results, steps);
    if (errors == 0) begin
      $display("rpm_lag_slew_filter_test: done, clean");
    end else begin
      $display("rpm_lag_slew_filter_test: done, errors");
    end
    $finish;
  end
endmodule
